// File: rtl/spq_pkg.sv
// types and constants shared by the stable priority queue
package spq_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int VALUE_W       = 32;
  localparam int PRIO_W        = 16;
  localparam int OCC_W         = 5;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    action_t                   action;
    logic signed [VALUE_W-1:0] item_value;
    logic signed [PRIO_W-1:0]  item_priority;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] out_value;
    logic signed [PRIO_W-1:0]  out_priority;
    logic [OCC_W-1:0]          occupancy;
  } out_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  // broadcast to every cell for one transfer
  typedef struct packed {
    logic   ins;
    logic   shift_out;
    entry_t entry;
  } cell_cmd_t;

endpackage

// File: rtl/spq_cell.sv
// one slot of the sorted row: compare with the new entry and shift left or right
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               occupied,
  input  logic               left_gt,
  input  spq_pkg::entry_t    left_slot,
  input  spq_pkg::entry_t    right_slot,
  output spq_pkg::entry_t    slot,
  output logic               gt
);

  spq_pkg::entry_t slot_next;

  // new entry goes before this slot when the slot is empty or strictly greater
  assign gt = !occupied || (slot.prio > cmd.entry.prio);

  always_comb begin
    slot_next = slot;
    priority if (cmd.shift_out) begin
      slot_next = right_slot;
    end else if (cmd.ins && gt) begin
      if (left_gt) begin
        slot_next = left_slot;
      end else begin
        slot_next = cmd.entry;
      end
    end else begin
      slot_next = slot;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

// File: rtl/stable_priority_queue_core.sv
// Stable minimum priority queue built as a row of compare-and-shift cells.
// Input channel in_valid / in_stall / in_data carries one operation per
// transfer: an enqueue of a value and priority, or a dequeue of the front.
// Entries are kept sorted by ascending priority; equal priorities leave in
// arrival order. Every input transfer gives exactly one result on
// out_valid / out_stall / out_data: a status, the removed entry on a good
// dequeue (zero otherwise), and the occupancy after the operation.
// An enqueue into a full queue is dropped with a full status; a dequeue of
// an empty queue reports empty and leaves the queue alone.
// The result is registered and valid in the cycle after the input transfer.
// Each cell does one compare and one neighbor move per cycle, so one item is taken
// every cycle while results are drained.
// When the receiver stalls, the result register holds and in_stall rises
// until it is taken; a new item is accepted in the cycle the old result
// leaves. Reset empties the queue and clears out_valid; no clearing pass.
module stable_priority_queue_core #(
  parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_item_t out_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               accept;
  logic               is_full;
  logic               is_empty;
  spq_pkg::cell_cmd_t cmd;
  spq_pkg::out_item_t res_next;

  spq_pkg::entry_t slots [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] gts;
  logic [QUEUE_DEPTH-1:0] occ;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_full  = (count == CW'(QUEUE_DEPTH));
  assign is_empty = (count == '0);

  always_comb begin
    cmd.ins                = accept && (in_data.action == spq_pkg::ACT_ENQ) && !is_full;
    cmd.shift_out          = accept && (in_data.action == spq_pkg::ACT_DEQ) && !is_empty;
    cmd.entry.value        = in_data.item_value;
    cmd.entry.prio         = in_data.item_priority;

    count_next = count;
    if (cmd.ins) begin
      count_next = count + CW'(1);
    end else if (cmd.shift_out) begin
      count_next = count - CW'(1);
    end

    res_next.status       = spq_pkg::ST_DONE;
    res_next.out_value    = '0;
    res_next.out_priority = '0;
    res_next.occupancy    = spq_pkg::OCC_W'(count_next);
    unique case (in_data.action)
      spq_pkg::ACT_ENQ: begin
        if (is_full) begin
          res_next.status = spq_pkg::ST_FULL;
        end
      end
      spq_pkg::ACT_DEQ: begin
        if (is_empty) begin
          res_next.status = spq_pkg::ST_EMPTY;
        end else begin
          res_next.out_value    = slots[0].value;
          res_next.out_priority = slots[0].prio;
        end
      end
      default: res_next.status = spq_pkg::ST_DONE;
    endcase
  end

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic            left_gt;
      spq_pkg::entry_t left_slot;
      spq_pkg::entry_t right_slot;

      assign occ[i] = (count > CW'(i));

      if (i == 0) begin : g_head
        assign left_gt   = 1'b0;
        assign left_slot = cmd.entry;
      end else begin : g_body
        assign left_gt   = gts[i-1];
        assign left_slot = slots[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign right_slot = slots[i];
      end else begin : g_inner
        assign right_slot = slots[i+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (occ[i]),
        .left_gt    (left_gt),
        .left_slot  (left_slot),
        .right_slot (right_slot),
        .slot       (slots[i]),
        .gt         (gts[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res_next;
    end
  end

endmodule
